>>> rtl/hrit_pkg.sv
`default_nettype none

package hrit_pkg;

  // Prefix byte that opens a long item.
  localparam logic [7:0] LONG_PREFIX = 8'hFE;

  // Fields of the prefix byte of a short item.
  localparam logic [7:0] SIZE_MASK = 8'h03;
  localparam logic [7:0] TYPE_MASK = 8'h0C;
  localparam logic [7:0] TAG_MASK  = 8'hF0;

  // Size code of a short item that declares four data bytes.
  localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

  // Parser phases.
  typedef enum logic [4:0] {
    PH_PREFIX     = 5'b00001,
    PH_LONG_LEN   = 5'b00010,
    PH_LONG_TAG   = 5'b00100,
    PH_SHORT_DATA = 5'b01000,
    PH_LONG_DATA  = 5'b10000
  } phase_t;

  // One descriptor byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_descriptor;
  } in_item_t;

  // One parsed item.
  typedef struct packed {
    logic [1:0]  item_type;
    logic [7:0]  item_tag;
    logic        is_long_item;
    logic [7:0]  data_length;
    logic [31:0] item_value;
    logic        truncated;
    logic        final_item;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/hid_report_item_tokenizer.sv
`default_nettype none
// The byte that completes a result sits in the input register; its result is written to the
// result register, which drives the output. A blocked result register holds the byte back.
// Throughput: one descriptor byte per cycle unless a result is blocked; single-pass state update.
// Reset: synchronous, active low; the parser expects a prefix byte and all held fields are zero.

module hid_report_item_tokenizer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hrit_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hrit_pkg::out_item_t      out_data
);

  // Input register.
  logic                in_vld_r;
  logic                in_vld_nxt;
  hrit_pkg::in_item_t  in_item_r;

  // Parser state.
  hrit_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic [31:0]      value_accum_r, value_accum_nxt;
  logic [1:0]       byte_pos_r, byte_pos_nxt;
  logic [1:0]       held_type_r, held_type_nxt;
  logic [7:0]       held_tag_r, held_tag_nxt;
  logic [7:0]       held_length_r, held_length_nxt;
  logic             held_long_r, held_long_nxt;

  // Result register.
  logic                out_vld_r;
  logic                out_vld_nxt;
  hrit_pkg::out_item_t out_item_r;

  logic                emit;
  logic                trunc;
  logic                adv;
  logic                out_free;
  logic                in_accept;
  logic [7:0]          b;
  logic                fin;
  hrit_pkg::out_item_t res;

  assign b   = in_item_r.data_byte;
  assign fin = in_item_r.end_of_descriptor;

  // Next parser state and the result that this byte produces.
  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    value_accum_nxt = value_accum_r;
    byte_pos_nxt    = byte_pos_r;
    held_type_nxt   = held_type_r;
    held_tag_nxt    = held_tag_r;
    held_length_nxt = held_length_r;
    held_long_nxt   = held_long_r;
    emit            = 1'b0;
    trunc           = 1'b0;

    unique case (phase_r)
      hrit_pkg::PH_LONG_LEN: begin
        held_length_nxt = b;
        if (fin) begin
          emit  = 1'b1;
          trunc = 1'b1;
        end else begin
          phase_nxt = hrit_pkg::PH_LONG_TAG;
        end
      end
      hrit_pkg::PH_LONG_TAG: begin
        held_tag_nxt = b;
        if (held_length_r == 8'd0) begin
          emit = 1'b1;
        end else if (fin) begin
          emit  = 1'b1;
          trunc = 1'b1;
        end else begin
          bytes_left_nxt = held_length_r;
          phase_nxt      = hrit_pkg::PH_LONG_DATA;
        end
      end
      hrit_pkg::PH_SHORT_DATA: begin
        for (int i = 0; i < 4; i++) begin
          if (byte_pos_r == 2'(i)) begin
            value_accum_nxt[8*i +: 8] = value_accum_r[8*i +: 8] | b;
          end
        end
        byte_pos_nxt   = byte_pos_r + 2'd1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_nxt == 8'd0) begin
          emit = 1'b1;
        end else if (fin) begin
          emit  = 1'b1;
          trunc = 1'b1;
        end
      end
      hrit_pkg::PH_LONG_DATA: begin
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_nxt == 8'd0) begin
          emit = 1'b1;
        end else if (fin) begin
          emit  = 1'b1;
          trunc = 1'b1;
        end
      end
      default: begin
        // Prefix byte; unused phase codes land here as well.
        value_accum_nxt = '0;
        byte_pos_nxt    = '0;
        bytes_left_nxt  = '0;
        held_type_nxt   = 2'((b & hrit_pkg::TYPE_MASK) >> 2);
        if (b == hrit_pkg::LONG_PREFIX) begin
          held_long_nxt   = 1'b1;
          held_tag_nxt    = '0;
          held_length_nxt = '0;
          if (fin) begin
            emit  = 1'b1;
            trunc = 1'b1;
          end else begin
            phase_nxt = hrit_pkg::PH_LONG_LEN;
          end
        end else begin
          held_long_nxt = 1'b0;
          held_tag_nxt  = (b & hrit_pkg::TAG_MASK) >> 4;
          if (2'(b & hrit_pkg::SIZE_MASK) == hrit_pkg::SIZE_CODE_FOUR) begin
            held_length_nxt = 8'd4;
          end else begin
            held_length_nxt = b & hrit_pkg::SIZE_MASK;
          end
          if (held_length_nxt == 8'd0) begin
            emit = 1'b1;
          end else if (fin) begin
            emit  = 1'b1;
            trunc = 1'b1;
          end else begin
            bytes_left_nxt = held_length_nxt;
            phase_nxt      = hrit_pkg::PH_SHORT_DATA;
          end
        end
      end
    endcase

    // The result carries the held fields as updated by this byte.
    res.item_type    = held_type_nxt;
    res.item_tag     = held_tag_nxt;
    res.is_long_item = held_long_nxt;
    res.data_length  = held_length_nxt;
    res.item_value   = held_long_nxt ? 32'd0 : value_accum_nxt;
    res.truncated    = trunc;
    res.final_item   = fin;

    // A finished item returns to the prefix phase; the last byte also clears the held state.
    if (emit) begin
      phase_nxt = hrit_pkg::PH_PREFIX;
      if (fin) begin
        bytes_left_nxt  = '0;
        value_accum_nxt = '0;
        byte_pos_nxt    = '0;
        held_type_nxt   = '0;
        held_tag_nxt    = '0;
        held_length_nxt = '0;
        held_long_nxt   = 1'b0;
      end
    end
  end

  // Handshake: the held byte moves on unless it has a result and the result register is busy.
  assign out_free  = !out_vld_r || !out_stall;
  assign adv       = in_vld_r && (!emit || out_free);
  assign in_stall  = in_vld_r && !adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && emit) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control and parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      phase_r       <= hrit_pkg::PH_PREFIX;
      bytes_left_r  <= '0;
      value_accum_r <= '0;
      byte_pos_r    <= '0;
      held_type_r   <= '0;
      held_tag_r    <= '0;
      held_length_r <= '0;
      held_long_r   <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        phase_r       <= phase_nxt;
        bytes_left_r  <= bytes_left_nxt;
        value_accum_r <= value_accum_nxt;
        byte_pos_r    <= byte_pos_nxt;
        held_type_r   <= held_type_nxt;
        held_tag_r    <= held_tag_nxt;
        held_length_r <= held_length_nxt;
        held_long_r   <= held_long_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
    if (adv && emit) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // The last byte always leaves the parser waiting for a prefix with cleared state.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && fin |=> phase_r == hrit_pkg::PH_PREFIX && held_tag_r == 8'd0
                   && held_length_r == 8'd0 && !held_long_r)
    else $error("parser state not cleared after the last byte");

  // Every byte flagged as last produces a transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && fin |-> emit)
    else $error("last byte produced no transaction");

  // Long items never report data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.is_long_item |-> out_item_r.item_value == 32'd0)
    else $error("long item with a nonzero value");

  // Short items carry a four-bit tag and a length of 0, 1, 2 or 4.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_item_r.is_long_item |->
      out_item_r.item_tag[7:4] == 4'd0 &&
      (out_item_r.data_length == 8'd0 || out_item_r.data_length == 8'd1 ||
       out_item_r.data_length == 8'd2 || out_item_r.data_length == 8'd4))
    else $error("malformed short item");

  // A stall on the input only happens while a byte is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && emit && out_vld_r && out_stall)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

>>> tb/tb_hid_report_item_tokenizer.sv
`timescale 1ns / 1ps

module tb_hid_report_item_tokenizer;

  // Idling modes for the two channels.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 320;
  localparam int SHOWN_LIMIT    = 10;
  localparam int SETTLE_CYCLES  = 20;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  hrit_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hrit_pkg::out_item_t out_data;

  hid_report_item_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Bytes waiting to be offered, and tokens the parser is expected to produce.
  hrit_pkg::in_item_t  descriptor_bytes[$];
  hrit_pkg::out_item_t expected_tokens[$];

  int idle_mode = IDLE_NONE;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;

  // Shadow parser state.
  hrit_pkg::phase_t parse_phase_q;
  logic [7:0]       bytes_left_q;
  logic [31:0]      value_q;
  logic [1:0]       byte_pos_q;
  logic [1:0]       held_type_q;
  logic [7:0]       held_tag_q;
  logic [7:0]       held_len_q;
  logic             held_long_q;

  function void clear_parser();
    parse_phase_q = hrit_pkg::PH_PREFIX;
    bytes_left_q  = '0;
    value_q       = '0;
    byte_pos_q    = '0;
    held_type_q   = '0;
    held_tag_q    = '0;
    held_len_q    = '0;
    held_long_q   = 1'b0;
  endfunction

  // Record the token for the item held so far and go back to the prefix.
  function automatic void close_item(bit trunc, bit fin);
    hrit_pkg::out_item_t tok;
    tok.item_type    = held_type_q;
    tok.item_tag     = held_tag_q;
    tok.is_long_item = held_long_q;
    tok.data_length  = held_len_q;
    tok.item_value   = held_long_q ? 32'd0 : value_q;
    tok.truncated    = trunc;
    tok.final_item   = fin;
    expected_tokens.push_back(tok);
    if (fin) begin
      clear_parser();
    end else begin
      parse_phase_q = hrit_pkg::PH_PREFIX;
    end
  endfunction

  // Advance the shadow parser by one accepted descriptor byte.
  function automatic void tokenize_byte(hrit_pkg::in_item_t it);
    logic [7:0] b;
    logic       fin;
    b   = it.data_byte;
    fin = it.end_of_descriptor;
    case (parse_phase_q)
      hrit_pkg::PH_LONG_LEN: begin
        held_len_q = b;
        if (fin) close_item(1'b1, 1'b1);
        else parse_phase_q = hrit_pkg::PH_LONG_TAG;
      end
      hrit_pkg::PH_LONG_TAG: begin
        held_tag_q = b;
        if (held_len_q == 8'd0) begin
          close_item(1'b0, fin);
        end else if (fin) begin
          close_item(1'b1, 1'b1);
        end else begin
          bytes_left_q  = held_len_q;
          parse_phase_q = hrit_pkg::PH_LONG_DATA;
        end
      end
      hrit_pkg::PH_SHORT_DATA: begin
        value_q      = value_q | ({24'd0, b} << (8 * byte_pos_q));
        byte_pos_q   = byte_pos_q + 2'd1;
        bytes_left_q = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd0) close_item(1'b0, fin);
        else if (fin) close_item(1'b1, 1'b1);
      end
      hrit_pkg::PH_LONG_DATA: begin
        bytes_left_q = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd0) close_item(1'b0, fin);
        else if (fin) close_item(1'b1, 1'b1);
      end
      default: begin
        value_q      = '0;
        byte_pos_q   = '0;
        bytes_left_q = '0;
        held_type_q  = b[3:2];
        if (b == hrit_pkg::LONG_PREFIX) begin
          held_long_q = 1'b1;
          held_tag_q  = '0;
          held_len_q  = '0;
          if (fin) close_item(1'b1, 1'b1);
          else parse_phase_q = hrit_pkg::PH_LONG_LEN;
        end else begin
          held_long_q = 1'b0;
          held_tag_q  = {4'd0, b[7:4]};
          held_len_q  = (b[1:0] == hrit_pkg::SIZE_CODE_FOUR) ? 8'd4 : {6'd0, b[1:0]};
          if (held_len_q == 8'd0) begin
            close_item(1'b0, fin);
          end else if (fin) begin
            close_item(1'b1, 1'b1);
          end else begin
            bytes_left_q  = held_len_q;
            parse_phase_q = hrit_pkg::PH_SHORT_DATA;
          end
        end
      end
    endcase
  endfunction

  function bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 78;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 7;
    return 1'b0;
  endfunction

  function bit receiver_stalls();
    if (idle_mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 78;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 7;
    return 1'b0;
  endfunction

  function string fmt_token(hrit_pkg::out_item_t t);
    return $sformatf("type=%0d tag=%02h long=%0b len=%0d value=%08h trunc=%0b final=%0b",
                     t.item_type, t.item_tag, t.is_long_item, t.data_length,
                     t.item_value, t.truncated, t.final_item);
  endfunction

  // Driver: offer queued bytes, holding each one while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) tokenize_byte(in_data);
      if (in_valid && in_stall) begin
        // The stalled transaction stays on the bus unchanged.
      end else if (descriptor_bytes.size() > 0 && !sender_idles()) begin
        in_valid <= 1'b1;
        in_data  <= descriptor_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= receiver_stalls();
    end
  end

  // Monitor: compare every accepted token with the oldest expectation.
  always @(posedge clk) begin
    hrit_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_LIMIT)
          $display("unexpected token: %s", fmt_token(out_data));
      end else begin
        want = expected_tokens.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= SHOWN_LIMIT) begin
            $display("token mismatch: expected %s", fmt_token(want));
            $display("                actual   %s", fmt_token(out_data));
          end
        end
      end
    end
  end

  task automatic queue_byte(logic [7:0] b, logic fin);
    hrit_pkg::in_item_t one;
    one.data_byte         = b;
    one.end_of_descriptor = fin;
    descriptor_bytes.push_back(one);
  endtask

  // Queue one random descriptor: mostly well-formed items, sometimes cut short,
  // occasionally plain noise.
  task automatic queue_descriptor(output int added);
    logic [7:0] body[$];
    logic [7:0] pfx;
    int n_items;
    int len;
    int cut;
    int i;
    body = {};
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
    end else begin
      n_items = $urandom_range(1, 8);
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 15) begin
          len = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
          body.push_back(hrit_pkg::LONG_PREFIX);
          body.push_back(8'(len));
          body.push_back(8'($urandom));
          repeat (len) body.push_back(8'($urandom));
        end else begin
          pfx = 8'($urandom);
          while (pfx == hrit_pkg::LONG_PREFIX) pfx = 8'($urandom);
          body.push_back(pfx);
          len = (pfx[1:0] == hrit_pkg::SIZE_CODE_FOUR) ? 4 : int'(pfx[1:0]);
          repeat (len) body.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        cut = $urandom_range(1, body.size());
        while (body.size() > cut) void'(body.pop_back());
      end
    end
    for (i = 0; i < body.size(); i++) queue_byte(body[i], i == body.size() - 1);
    added = body.size();
  endtask

  // Sender pause: nothing new until every expected token has arrived.
  task automatic wait_drained();
    while (descriptor_bytes.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int added;
    int queued;
    int m;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed descriptor: zero-length item, four-byte item with all-ones
    // prefix, long item with data, zero-length long item, one- and two-byte
    // items, and a complete item on the final byte.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(hrit_pkg::LONG_PREFIX, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(hrit_pkg::LONG_PREFIX, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h05, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h0A, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h00, 1'b1);
    // Truncated short item, long item ended at its prefix, and long item
    // ended at its length byte.
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b1);
    queue_byte(hrit_pkg::LONG_PREFIX, 1'b1);
    queue_byte(hrit_pkg::LONG_PREFIX, 1'b0);
    queue_byte(8'h05, 1'b1);
    wait_drained();

    // Random phases, one per idling mode.
    for (m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      idle_mode = m;
      queued = 0;
      while (queued < PHASE_BYTES) begin
        queue_descriptor(added);
        queued += added;
      end
      // With the sender still busy, a long receiver hold backs the block up.
      if (m == IDLE_NONE) hold_requests++;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/hrit_pkg.sv
rtl/hid_report_item_tokenizer.sv
tb/tb_hid_report_item_tokenizer.sv
